FILE: hdl/cdcf_pkg.sv
package cdcf_pkg;

    localparam int DT_W     = 16;
    localparam int ID_W     = 16;
    localparam int POS_W    = 32;
    localparam int OMEGA_W  = 24;
    localparam int MC_W     = 31;
    localparam int SNAP_W   = 16;
    localparam int CFG_A_W  = 2;
    localparam int CFG_D_W  = 31;
    localparam int IN_W     = 160;
    localparam int IN_U_W   = 2;
    localparam int OUT_W    = 144;

    localparam int MUL_A_W  = 41;
    localparam int MUL_B_W  = 25;
    localparam int PROD_W   = 66;
    localparam int X_W      = 24;
    localparam int X2_W     = 32;
    localparam int X3_W     = 40;
    localparam int DEN_W    = 40;
    localparam int E_W      = 17;
    localparam int WIDE_W   = 40;
    localparam int SNAP_LIM = 20;
    localparam int SQ_W     = 40;
    localparam int CNT_W    = 5;

    localparam logic [CNT_W-1:0]   DIV_STEPS = 5'd17;
    localparam logic [DEN_W-1:0]   DEN_ONE   = 40'd65536;
    localparam logic [DEN_W-1:0]   REM_START = 40'd32768;
    localparam logic [MUL_B_W-1:0] C_Q16_048  = 25'd31457;
    localparam logic [MUL_B_W-1:0] C_Q16_0235 = 25'd15401;

    localparam logic [OMEGA_W-1:0] OMEGA_RST = 24'd468114;
    localparam logic [MC_W-1:0]    MC_RST    = 31'd5734400;
    localparam logic [SNAP_W-1:0]  SNAP_RST  = 16'd25;

    localparam logic [CFG_A_W-1:0] CFG_OMEGA      = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_MAX_CHANGE = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_SNAP_SQ    = 2'd2;

    localparam logic [1:0] SPR_AIM_X = 2'd0;
    localparam logic [1:0] SPR_AIM_Y = 2'd1;
    localparam logic [1:0] SPR_CAM_X = 2'd2;
    localparam logic [1:0] SPR_CAM_Y = 2'd3;

    typedef enum logic [21:0] {
        S_IDLE = 22'h000001,
        S_X    = 22'h000002,
        S_X2   = 22'h000004,
        S_X3   = 22'h000008,
        S_D2   = 22'h000010,
        S_D3   = 22'h000020,
        S_D4   = 22'h000040,
        S_DIV  = 22'h000080,
        S_BR   = 22'h000100,
        S_SQX  = 22'h000200,
        S_SQY  = 22'h000400,
        S_SQC  = 22'h000800,
        SP_C   = 22'h001000,
        SP_WC  = 22'h002000,
        SP_S   = 22'h004000,
        SP_T   = 22'h008000,
        SP_WT  = 22'h010000,
        SP_V1  = 22'h020000,
        SP_VM  = 22'h040000,
        SP_VW  = 22'h080000,
        SP_PW  = 22'h100000,
        S_DONE = 22'h200000
    } state_t;

    function automatic logic signed [WIDE_W-1:0] sat40(input logic signed [63:0] v);
        if (v[63:WIDE_W-1] == {(64-WIDE_W+1){v[63]}})
            return v[WIDE_W-1:0];
        else if (v[63])
            return {1'b1, {(WIDE_W-1){1'b0}}};
        else
            return {1'b0, {(WIDE_W-1){1'b1}}};
    endfunction

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [63:0] v);
        if (v[63:POS_W-1] == {(64-POS_W+1){v[63]}})
            return v[POS_W-1:0];
        else if (v[63])
            return {1'b1, {(POS_W-1){1'b0}}};
        else
            return {1'b0, {(POS_W-1){1'b1}}};
    endfunction

endpackage

FILE: hdl/critically_damped_camera_follow_core.sv
// Critically damped camera follow. Each accepted request carries a frame time and a
// target; the block updates a camera position and, while gliding between targets, a
// smoothed aim point, each chasing its goal through a critically damped spring with
// exp(-omega*dt) taken from a rational polynomial, and returns one result. All
// multiplies go through one shared 41x25 signed multiplier with a registered product,
// stepped by a one-hot sequencer; exp is finished by a 17-step restoring divider. A
// request with no valid target goes straight to loading its result; a valid one runs
// the polynomial, the divider, a branch, the snap test when the target changes while
// the previous one is alive, the spring over two or four axes, and the load of the
// result. Input is not ready while a request is in work; a finished result waits in the
// output register, and the load stalls while a previous result there is not yet taken.
module critically_damped_camera_follow_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cdcf_pkg::CFG_A_W-1:0]  cfg_addr,
    input  logic [cdcf_pkg::CFG_D_W-1:0]  cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // step_time, target_id, target_x, target_y, previous_x, previous_y
    input  logic [cdcf_pkg::IN_W-1:0]     s_tdata,
    // target_valid, previous_alive
    input  logic [cdcf_pkg::IN_U_W-1:0]   s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // camera_x, camera_y, aim_x, aim_y, followed_id
    output logic [cdcf_pkg::OUT_W-1:0]    m_tdata,
    // in_transition
    output logic                          m_tuser
);
    import cdcf_pkg::*;

    state_t state_reg;

    logic [OMEGA_W-1:0] omega_reg;
    logic [MC_W-1:0]    mc_reg;
    logic [SNAP_W-1:0]  snap_reg;

    logic signed [POS_W-1:0] cam_px_reg, cam_py_reg, cam_vx_reg, cam_vy_reg;
    logic signed [POS_W-1:0] aim_px_reg, aim_py_reg, aim_vx_reg, aim_vy_reg;
    logic [ID_W-1:0]         fol_id_reg;
    logic                    present_reg;

    logic [DT_W-1:0]         dt_reg;
    logic [ID_W-1:0]         id_reg;
    logic signed [POS_W-1:0] tx_reg, ty_reg;
    logic                    alive_reg;
    logic [SNAP_LIM-1:0]     ax_reg, ay_reg;
    logic                    far_reg;

    logic [X_W-1:0]          x_reg;
    logic [X2_W-1:0]         x2_reg;
    logic [X3_W-1:0]         x3_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [DEN_W-1:0]        rem_reg;
    logic [E_W-1:0]          e_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic                    glide_reg;
    logic [1:0]              spr_reg;

    logic signed [POS_W-1:0]   c_reg;
    logic signed [WIDE_W-1:0]  s_reg, p_reg, v1_reg;
    logic signed [PROD_W-1:0]  prod_reg;

    logic                    out_valid_reg;
    logic [OUT_W-1:0]        out_data_reg;
    logic                    out_user_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-17:0] prod_sh;

    logic signed [POS_W-1:0] sp_from, sp_to, sp_vel;
    logic signed [POS_W:0]   diff, mc_pos, mc_neg;
    logic signed [POS_W-1:0] c_next;
    logic signed [WIDE_W-1:0] t_next;
    logic [DEN_W:0]          r2;
    logic                    r2_ge;
    logic [SQ_W:0]           sq_sum;
    logic                    beyond;

    logic signed [POS_W:0]   in_dx, in_dy;
    logic [POS_W:0]          in_ax, in_ay;
    logic                    s_acc;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_user_reg;

    assign prod_sh = $signed(prod_reg[PROD_W-1:16]);

    // snap distance components
    always_comb
    begin
        in_dx = 33'($signed(s_tdata[63:32])) - 33'($signed(s_tdata[127:96]));
        in_dy = 33'($signed(s_tdata[95:64])) - 33'($signed(s_tdata[159:128]));
        in_ax = in_dx[POS_W] ? 33'(-in_dx) : 33'(in_dx);
        in_ay = in_dy[POS_W] ? 33'(-in_dy) : 33'(in_dy);
    end

    // spring operands
    always_comb
    begin
        case (spr_reg)
            SPR_AIM_X:
            begin
                sp_from = aim_px_reg;
                sp_to   = tx_reg;
                sp_vel  = aim_vx_reg;
            end
            SPR_AIM_Y:
            begin
                sp_from = aim_py_reg;
                sp_to   = ty_reg;
                sp_vel  = aim_vy_reg;
            end
            SPR_CAM_X:
            begin
                sp_from = cam_px_reg;
                sp_to   = aim_px_reg;
                sp_vel  = cam_vx_reg;
            end
            default:
            begin
                sp_from = cam_py_reg;
                sp_to   = aim_py_reg;
                sp_vel  = cam_vy_reg;
            end
        endcase
    end

    // offset clamp
    always_comb
    begin
        diff   = 33'(sp_from) - 33'(sp_to);
        mc_pos = $signed({2'b00, mc_reg});
        mc_neg = -mc_pos;
        if (diff > mc_pos)
            c_next = mc_pos[POS_W-1:0];
        else if (diff < mc_neg)
            c_next = mc_neg[POS_W-1:0];
        else
            c_next = diff[POS_W-1:0];
    end

    assign t_next = $signed(prod_reg[55:16]);
    assign r2     = {rem_reg, 1'b0};
    assign r2_ge  = r2 >= {1'b0, den_reg};
    assign sq_sum = {1'b0, sq_reg} + {1'b0, prod_reg[SQ_W-1:0]};
    assign beyond = far_reg || (sq_sum > {1'b0, snap_reg, 24'd0});

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_X:
            begin
                mul_a = $signed(41'(dt_reg));
                mul_b = $signed({1'b0, omega_reg});
            end
            S_X2:
            begin
                mul_a = $signed(41'(prod_reg[39:16]));
                mul_b = $signed({1'b0, prod_reg[39:16]});
            end
            S_X3:
            begin
                mul_a = $signed(41'(prod_reg[47:16]));
                mul_b = $signed({1'b0, x_reg});
            end
            S_D2:
            begin
                mul_a = $signed(41'(x2_reg));
                mul_b = $signed(C_Q16_048);
            end
            S_D3:
            begin
                mul_a = $signed(41'(x3_reg));
                mul_b = $signed(C_Q16_0235);
            end
            S_SQX:
            begin
                mul_a = $signed(41'(ax_reg));
                mul_b = $signed(25'(ax_reg));
            end
            S_SQY:
            begin
                mul_a = $signed(41'(ay_reg));
                mul_b = $signed(25'(ay_reg));
            end
            SP_WC:
            begin
                mul_a = 41'(c_reg);
                mul_b = $signed({1'b0, omega_reg});
            end
            SP_T:
            begin
                mul_a = 41'(s_reg);
                mul_b = $signed(25'(dt_reg));
            end
            SP_WT:
            begin
                mul_a = 41'(t_next);
                mul_b = $signed({1'b0, omega_reg});
            end
            SP_VM:
            begin
                mul_a = 41'(v1_reg);
                mul_b = $signed(25'(e_reg));
            end
            SP_VW:
            begin
                mul_a = 41'(p_reg);
                mul_b = $signed(25'(e_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            omega_reg     <= OMEGA_RST;
            mc_reg        <= MC_RST;
            snap_reg      <= SNAP_RST;
            cam_px_reg    <= '0;
            cam_py_reg    <= '0;
            cam_vx_reg    <= '0;
            cam_vy_reg    <= '0;
            aim_px_reg    <= '0;
            aim_py_reg    <= '0;
            aim_vx_reg    <= '0;
            aim_vy_reg    <= '0;
            fol_id_reg    <= '0;
            present_reg   <= 1'b0;
            glide_reg     <= 1'b0;
            spr_reg       <= SPR_CAM_X;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            prod_reg <= prod_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_addr)
                    CFG_OMEGA:      omega_reg <= cfg_data[OMEGA_W-1:0];
                    CFG_MAX_CHANGE: mc_reg    <= cfg_data[MC_W-1:0];
                    CFG_SNAP_SQ:    snap_reg  <= cfg_data[SNAP_W-1:0];
                    default:        ;
                endcase
            end

            if (out_valid_reg && m_tready && (state_reg != S_DONE))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (s_acc)
                    begin
                        dt_reg    <= s_tdata[15:0];
                        id_reg    <= s_tdata[31:16];
                        tx_reg    <= $signed(s_tdata[63:32]);
                        ty_reg    <= $signed(s_tdata[95:64]);
                        alive_reg <= s_tuser[1];
                        ax_reg    <= in_ax[SNAP_LIM-1:0];
                        ay_reg    <= in_ay[SNAP_LIM-1:0];
                        far_reg   <= (in_ax[POS_W:SNAP_LIM] != '0) ||
                                     (in_ay[POS_W:SNAP_LIM] != '0);
                        glide_reg <= 1'b0;
                        state_reg <= s_tuser[0] ? S_X : S_DONE;
                    end
                end
                S_X:
                    state_reg <= S_X2;
                S_X2:
                begin
                    x_reg     <= prod_reg[39:16];
                    den_reg   <= DEN_ONE + 40'(prod_reg[39:16]);
                    state_reg <= S_X3;
                end
                S_X3:
                begin
                    x2_reg    <= prod_reg[47:16];
                    state_reg <= S_D2;
                end
                S_D2:
                begin
                    x3_reg    <= prod_reg[55:16];
                    state_reg <= S_D3;
                end
                S_D3:
                begin
                    den_reg   <= den_reg + prod_reg[55:16];
                    state_reg <= S_D4;
                end
                S_D4:
                begin
                    den_reg   <= den_reg + prod_reg[55:16];
                    rem_reg   <= REM_START;
                    e_reg     <= '0;
                    cnt_reg   <= DIV_STEPS;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg <= r2_ge ? DEN_W'(r2 - {1'b0, den_reg}) : r2[DEN_W-1:0];
                    e_reg   <= {e_reg[E_W-2:0], r2_ge};
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd1)
                        state_reg <= S_BR;
                end
                S_BR:
                begin
                    spr_reg <= SPR_CAM_X;
                    if (present_reg && (id_reg == fol_id_reg))
                    begin
                        aim_px_reg <= tx_reg;
                        aim_py_reg <= ty_reg;
                        state_reg  <= SP_C;
                    end
                    else if (present_reg && alive_reg)
                        state_reg <= S_SQX;
                    else
                    begin
                        fol_id_reg  <= id_reg;
                        present_reg <= 1'b1;
                        state_reg   <= SP_C;
                    end
                end
                S_SQX:
                    state_reg <= S_SQY;
                S_SQY:
                begin
                    sq_reg    <= prod_reg[SQ_W-1:0];
                    state_reg <= S_SQC;
                end
                S_SQC:
                begin
                    if (beyond)
                    begin
                        glide_reg <= 1'b1;
                        spr_reg   <= SPR_AIM_X;
                    end
                    else
                    begin
                        fol_id_reg <= id_reg;
                        aim_px_reg <= tx_reg;
                        aim_py_reg <= ty_reg;
                        spr_reg    <= SPR_CAM_X;
                    end
                    state_reg <= SP_C;
                end
                SP_C:
                begin
                    c_reg     <= c_next;
                    state_reg <= SP_WC;
                end
                SP_WC:
                    state_reg <= SP_S;
                SP_S:
                begin
                    s_reg     <= sat40(64'(sp_vel) + 64'(prod_sh));
                    state_reg <= SP_T;
                end
                SP_T:
                    state_reg <= SP_WT;
                SP_WT:
                begin
                    p_reg     <= sat40(64'(c_reg) + 64'(t_next));
                    state_reg <= SP_V1;
                end
                SP_V1:
                begin
                    v1_reg    <= sat40(64'(sp_vel) - 64'(prod_sh));
                    state_reg <= SP_VM;
                end
                SP_VM:
                    state_reg <= SP_VW;
                SP_VW:
                begin
                    case (spr_reg)
                        SPR_AIM_X: aim_vx_reg <= sat32(64'(prod_sh));
                        SPR_AIM_Y: aim_vy_reg <= sat32(64'(prod_sh));
                        SPR_CAM_X: cam_vx_reg <= sat32(64'(prod_sh));
                        default:   cam_vy_reg <= sat32(64'(prod_sh));
                    endcase
                    state_reg <= SP_PW;
                end
                SP_PW:
                begin
                    case (spr_reg)
                        SPR_AIM_X: aim_px_reg <= sat32(64'(sp_to) + 64'(prod_sh));
                        SPR_AIM_Y: aim_py_reg <= sat32(64'(sp_to) + 64'(prod_sh));
                        SPR_CAM_X: cam_px_reg <= sat32(64'(sp_to) + 64'(prod_sh));
                        default:   cam_py_reg <= sat32(64'(sp_to) + 64'(prod_sh));
                    endcase
                    spr_reg   <= spr_reg + 2'd1;
                    state_reg <= (spr_reg == SPR_CAM_Y) ? S_DONE : SP_C;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {(present_reg ? fol_id_reg : {ID_W{1'b0}}),
                                          aim_py_reg, aim_px_reg, cam_py_reg, cam_px_reg};
                        out_user_reg  <= glide_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BR) |-> (e_reg <= 17'd65536))
        else $error("exp factor above one");

    a_glide_followed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> present_reg)
        else $error("glide reported with nothing followed");

    a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!out_valid_reg || m_tready)) |=> (m_tvalid && s_tready))
        else $error("result not loaded on completion");

endmodule
